// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker in gatt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define GATT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gatt: assertion failed");

// Checked on every rising edge, reset included.
`define GATT_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("gatt: reset assertion failed");

`endif

// ===== sv/gatt_pkg.sv =====
package gatt_pkg;

    localparam int TIME_BITS   = 32;
    localparam int VALUE_BITS  = 32;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam int LIMIT_W     = 32;
    localparam int GAP_W       = 32;
    localparam int AREA_W      = 64;
    localparam int WORKED_W    = 32;
    localparam int SPAN_W      = 40;

    localparam int DELTA_W     = TIME_BITS + 1;
    localparam int SUM_W       = VALUE_BITS + 1;
    localparam int PROD_W      = SUM_W + DELTA_W;
    localparam int INC_W       = (PROD_W > AREA_W) ? PROD_W : AREA_W + 1;
    localparam int CMP_W       = (VALUE_BITS > LIMIT_W) ? VALUE_BITS : LIMIT_W;
    localparam int GAP_CMP_W   = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
    localparam int WSUM_W      = ((WORKED_W > TIME_BITS) ? WORKED_W : TIME_BITS) + 1;
    localparam int SPAN_SUM_W  = ((SPAN_W > DELTA_W) ? SPAN_W : DELTA_W) + 1;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_ENABLE   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_ENABLE  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_LIMIT    = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_START_TIME   = CFG_INDEX_W'(5);
    localparam logic [CFG_INDEX_W-1:0] REG_COUNTER_MODE = CFG_INDEX_W'(6);

    localparam logic [LIMIT_W-1:0]   LOW_LIMIT_RESET  = {1'b1, {(LIMIT_W-1){1'b0}}};
    localparam logic [LIMIT_W-1:0]   HIGH_LIMIT_RESET = {1'b0, {(LIMIT_W-1){1'b1}}};
    localparam logic [GAP_W-1:0]     GAP_LIMIT_RESET  = GAP_W'(2880);
    localparam logic [TIME_BITS-1:0] START_TIME_RESET = '0;

    typedef struct packed {
        logic [LIMIT_W-1:0]   low_limit;
        logic [LIMIT_W-1:0]   high_limit;
        logic                 low_enable;
        logic                 high_enable;
        logic [GAP_W-1:0]     gap_limit;
        logic                 counter_mode;
        logic                 start_load;
        logic [TIME_BITS-1:0] start_time;
    } cfg_t;

    typedef struct packed {
        logic [AREA_W-1:0]  area_inc;
        logic [DELTA_W-1:0] delta;
        logic               counted;
        logic               add_off;
        logic               add_wait;
    } span_t;

endpackage

// ===== sv/gatt_cfg.sv =====
module gatt_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gatt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gatt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gatt_pkg::cfg_t                   cfg
);
    import gatt_pkg::*;

    logic [LIMIT_W-1:0] low_limit_reg;
    logic [LIMIT_W-1:0] high_limit_reg;
    logic               low_enable_reg;
    logic               high_enable_reg;
    logic [GAP_W-1:0]   gap_limit_reg;
    logic               counter_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg    <= LOW_LIMIT_RESET;
            high_limit_reg   <= HIGH_LIMIT_RESET;
            low_enable_reg   <= 1'b0;
            high_enable_reg  <= 1'b0;
            gap_limit_reg    <= GAP_LIMIT_RESET;
            counter_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LOW_LIMIT:    low_limit_reg    <= cfg_data[LIMIT_W-1:0];
                REG_HIGH_LIMIT:   high_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_LOW_ENABLE:   low_enable_reg   <= cfg_data[0];
                REG_HIGH_ENABLE:  high_enable_reg  <= cfg_data[0];
                REG_GAP_LIMIT:    gap_limit_reg    <= cfg_data[GAP_W-1:0];
                REG_COUNTER_MODE: counter_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The start time is not kept here: a write loads the previous-time register directly.
    assign cfg.low_limit    = low_limit_reg;
    assign cfg.high_limit   = high_limit_reg;
    assign cfg.low_enable   = low_enable_reg;
    assign cfg.high_enable  = high_enable_reg;
    assign cfg.gap_limit    = gap_limit_reg;
    assign cfg.counter_mode = counter_mode_reg;
    assign cfg.start_load   = cfg_wr_en && (cfg_index == REG_START_TIME);
    assign cfg.start_time   = TIME_BITS'(cfg_data);

endmodule

// ===== sv/gatt_interval.sv =====
module gatt_interval (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  gatt_pkg::cfg_t                         cfg,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [gatt_pkg::TIME_BITS-1:0]         s_sample_time,
    input  logic signed [gatt_pkg::VALUE_BITS-1:0] s_sample_value,
    output logic                                   span_valid,
    input  logic                                   span_ready,
    output gatt_pkg::span_t                        span
);
    import gatt_pkg::*;

    logic [TIME_BITS-1:0]  prev_time_reg;
    logic [VALUE_BITS-1:0] prev_value_reg;

    logic                  a_valid_reg;
    logic [DELTA_W-1:0]    a_delta_reg;
    logic [SUM_W-1:0]      a_sum_reg;
    logic [VALUE_BITS-1:0] a_value_reg;
    logic                  a_prev_nz_reg;

    logic                  span_valid_reg;
    span_t                 span_reg;

    logic                  accept;
    logic                  b_ready;
    logic [DELTA_W-1:0]    delta_next;
    logic [SUM_W-1:0]      sum_next;

    logic                  below_gap;
    logic                  positive;
    logic signed [CMP_W-1:0] value_cmp;
    logic signed [CMP_W-1:0] low_cmp;
    logic signed [CMP_W-1:0] high_cmp;
    logic                  in_limits;
    logic                  value_nz;
    logic                  nonzero;
    logic                  qual;
    logic signed [PROD_W-1:0] product;
    logic signed [INC_W-1:0]  half;
    logic [INC_W-AREA_W:0]    half_top;
    logic [AREA_W-1:0]        inc_sat;
    span_t                 span_next;

    assign b_ready = !span_valid_reg || span_ready;
    assign s_ready = !a_valid_reg || b_ready;
    assign accept  = s_valid && s_ready;

    assign delta_next = DELTA_W'(s_sample_time) - DELTA_W'(prev_time_reg);
    assign sum_next   = SUM_W'(s_sample_value) + SUM_W'($signed(prev_value_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg  <= START_TIME_RESET;
            prev_value_reg <= '0;
        end else if (accept) begin
            prev_time_reg  <= s_sample_time;
            prev_value_reg <= s_sample_value;
        end else if (cfg.start_load) begin
            prev_time_reg  <= cfg.start_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_delta_reg   <= delta_next;
            a_sum_reg     <= sum_next;
            a_value_reg   <= s_sample_value;
            a_prev_nz_reg <= |prev_value_reg;
        end
    end

    // Qualification and trapezoid product; the halving rounds toward minus infinity.
    always_comb begin
        below_gap = a_delta_reg[DELTA_W-1]
                  || (GAP_CMP_W'(a_delta_reg[TIME_BITS-1:0]) < GAP_CMP_W'(cfg.gap_limit));
        positive  = !a_delta_reg[DELTA_W-1] && (|a_delta_reg);
        value_cmp = CMP_W'($signed(a_value_reg));
        low_cmp   = CMP_W'($signed(cfg.low_limit));
        high_cmp  = CMP_W'($signed(cfg.high_limit));
        in_limits = (!cfg.low_enable || (value_cmp >= low_cmp))
                 && (!cfg.high_enable || (value_cmp <= high_cmp));
        value_nz  = |a_value_reg;
        nonzero   = cfg.counter_mode ? (value_nz || a_prev_nz_reg) : value_nz;
        qual      = positive && below_gap && in_limits && nonzero;

        product   = PROD_W'($signed(a_sum_reg)) * PROD_W'($signed(a_delta_reg));
        half      = INC_W'(product >>> 1);
        half_top  = half[INC_W-1:AREA_W-1];
        if ((&half_top) || !(|half_top)) begin
            inc_sat = half[AREA_W-1:0];
        end else if (half[INC_W-1]) begin
            inc_sat = {1'b1, {(AREA_W-1){1'b0}}};
        end else begin
            inc_sat = {1'b0, {(AREA_W-1){1'b1}}};
        end

        span_next.area_inc = inc_sat;
        span_next.delta    = a_delta_reg;
        span_next.counted  = qual && (!cfg.counter_mode || a_prev_nz_reg);
        span_next.add_off  = !qual;
        span_next.add_wait = !qual && below_gap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_valid_reg <= 1'b0;
        end else if (b_ready) begin
            span_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            span_reg <= span_next;
        end
    end

    assign span_valid = span_valid_reg;
    assign span       = span_reg;

endmodule

// ===== sv/gatt_accum.sv =====
module gatt_accum (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 span_valid,
    output logic                                 span_ready,
    input  gatt_pkg::span_t                      span,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gatt_pkg::AREA_W-1:0]   m_area_total,
    output logic [gatt_pkg::WORKED_W-1:0]        m_worked_seconds,
    output logic signed [gatt_pkg::SPAN_W-1:0]   m_off_seconds,
    output logic signed [gatt_pkg::SPAN_W-1:0]   m_wait_seconds,
    output logic                                 m_interval_counted
);
    import gatt_pkg::*;

    logic                m_valid_reg;
    logic [AREA_W-1:0]   area_acc_reg;
    logic [WORKED_W-1:0] worked_acc_reg;
    logic [SPAN_W-1:0]   off_acc_reg;
    logic [SPAN_W-1:0]   wait_acc_reg;
    logic                counted_reg;

    logic                load;
    logic [AREA_W:0]     area_sum;
    logic [AREA_W-1:0]   area_next;
    logic [WSUM_W-1:0]   worked_sum;
    logic [WORKED_W-1:0] worked_next;
    logic [SPAN_SUM_W-1:0] off_sum;
    logic [SPAN_SUM_W-1:0] wait_sum;
    logic [SPAN_SUM_W-SPAN_W:0] off_top;
    logic [SPAN_SUM_W-SPAN_W:0] wait_top;
    logic [SPAN_W-1:0]   off_next;
    logic [SPAN_W-1:0]   wait_next;

    assign span_ready = !m_valid_reg || m_ready;
    assign load       = span_valid && span_ready;

    always_comb begin
        area_sum = {area_acc_reg[AREA_W-1], area_acc_reg}
                 + {span.area_inc[AREA_W-1], span.area_inc};
        if (area_sum[AREA_W] != area_sum[AREA_W-1]) begin
            area_next = area_sum[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}}
                                         : {1'b0, {(AREA_W-1){1'b1}}};
        end else begin
            area_next = area_sum[AREA_W-1:0];
        end

        worked_sum  = WSUM_W'(worked_acc_reg) + WSUM_W'(span.delta[TIME_BITS-1:0]);
        worked_next = (|worked_sum[WSUM_W-1:WORKED_W]) ? '1 : worked_sum[WORKED_W-1:0];

        off_sum  = SPAN_SUM_W'($signed(off_acc_reg)) + SPAN_SUM_W'($signed(span.delta));
        wait_sum = SPAN_SUM_W'($signed(wait_acc_reg)) + SPAN_SUM_W'($signed(span.delta));
        off_top  = off_sum[SPAN_SUM_W-1:SPAN_W-1];
        wait_top = wait_sum[SPAN_SUM_W-1:SPAN_W-1];

        if ((&off_top) || !(|off_top)) begin
            off_next = off_sum[SPAN_W-1:0];
        end else if (off_sum[SPAN_SUM_W-1]) begin
            off_next = {1'b1, {(SPAN_W-1){1'b0}}};
        end else begin
            off_next = {1'b0, {(SPAN_W-1){1'b1}}};
        end

        if ((&wait_top) || !(|wait_top)) begin
            wait_next = wait_sum[SPAN_W-1:0];
        end else if (wait_sum[SPAN_SUM_W-1]) begin
            wait_next = {1'b1, {(SPAN_W-1){1'b0}}};
        end else begin
            wait_next = {1'b0, {(SPAN_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            area_acc_reg   <= '0;
            worked_acc_reg <= '0;
            off_acc_reg    <= '0;
            wait_acc_reg   <= '0;
            counted_reg    <= 1'b0;
        end else begin
            if (span_ready) begin
                m_valid_reg <= span_valid;
            end
            if (load) begin
                if (span.counted) begin
                    area_acc_reg   <= area_next;
                    worked_acc_reg <= worked_next;
                end
                if (span.add_off) begin
                    off_acc_reg <= off_next;
                end
                if (span.add_wait) begin
                    wait_acc_reg <= wait_next;
                end
                counted_reg <= span.counted;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_area_total       = area_acc_reg;
    assign m_worked_seconds   = worked_acc_reg;
    assign m_off_seconds      = off_acc_reg;
    assign m_wait_seconds     = wait_acc_reg;
    assign m_interval_counted = counted_reg;

endmodule

// ===== sv/gap_aware_trapezoid_totalizer.sv =====
// An accepted sample word passes the sample stage, the interval stage and the totals stage in that order.
// Throughput: one word per cycle; the three registered stages stall only on m_ready.
// A waiting result stalls the input only once both stages behind it are full.
// Reset: aresetn is synchronous and active low; it empties the stages, zeroes the totals,
// restores the register defaults and sets the previous sample time to the default start time.
module gap_aware_trapezoid_totalizer (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [gatt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gatt_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [gatt_pkg::TIME_BITS-1:0]         s_sample_time,
    input  logic signed [gatt_pkg::VALUE_BITS-1:0] s_sample_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [gatt_pkg::AREA_W-1:0]     m_area_total,
    output logic [gatt_pkg::WORKED_W-1:0]          m_worked_seconds,
    output logic signed [gatt_pkg::SPAN_W-1:0]     m_off_seconds,
    output logic signed [gatt_pkg::SPAN_W-1:0]     m_wait_seconds,
    output logic                                   m_interval_counted
);
    import gatt_pkg::*;

    cfg_t  cfg;
    span_t span;
    logic  span_valid;
    logic  span_ready;

    gatt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gatt_interval u_interval (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_time  (s_sample_time),
        .s_sample_value (s_sample_value),
        .span_valid     (span_valid),
        .span_ready     (span_ready),
        .span           (span)
    );

    gatt_accum u_accum (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .span_valid         (span_valid),
        .span_ready         (span_ready),
        .span               (span),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_area_total       (m_area_total),
        .m_worked_seconds   (m_worked_seconds),
        .m_off_seconds      (m_off_seconds),
        .m_wait_seconds     (m_wait_seconds),
        .m_interval_counted (m_interval_counted)
    );

endmodule

// ===== sv/gatt_checker.sv =====
`include "assert_macros.svh"

module gatt_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic signed [gatt_pkg::AREA_W-1:0]     m_area_total,
    input  logic [gatt_pkg::WORKED_W-1:0]          m_worked_seconds,
    input  logic signed [gatt_pkg::SPAN_W-1:0]     m_off_seconds,
    input  logic signed [gatt_pkg::SPAN_W-1:0]     m_wait_seconds,
    input  logic                                   m_interval_counted
);

    // A stalled result word keeps its area and worked-time totals.
    `GATT_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_area_total) && $stable(m_worked_seconds))

    // No result word is shown in the cycle after reset.
    `GATT_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid)

    // A counted interval leaves the switched-off and wait totals alone and never lowers worked time.
    `GATT_ASSERT(a_counted_totals, m_valid && m_ready ##1 m_valid && m_interval_counted |-> $stable(m_off_seconds) && $stable(m_wait_seconds) && (m_worked_seconds >= $past(m_worked_seconds)))

    // An interval that is not counted changes neither the area nor worked time.
    `GATT_ASSERT(a_uncounted_totals, m_valid && m_ready ##1 m_valid && !m_interval_counted |-> $stable(m_area_total) && $stable(m_worked_seconds))

endmodule

bind gap_aware_trapezoid_totalizer gatt_checker u_gatt_checker (.*);

// ===== sim/totalizer_checker.sv =====
module totalizer_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [gatt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [gatt_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic [gatt_pkg::TIME_BITS-1:0]         s_sample_time,
    input  logic signed [gatt_pkg::VALUE_BITS-1:0] s_sample_value,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic signed [gatt_pkg::AREA_W-1:0]     m_area_total,
    input  logic [gatt_pkg::WORKED_W-1:0]          m_worked_seconds,
    input  logic signed [gatt_pkg::SPAN_W-1:0]     m_off_seconds,
    input  logic signed [gatt_pkg::SPAN_W-1:0]     m_wait_seconds,
    input  logic                                   m_interval_counted,
    output int                                     mismatches,
    output int                                     totals_pending
);
    import gatt_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [AREA_W-1:0] area;
        logic [WORKED_W-1:0]      worked;
        logic signed [SPAN_W-1:0] off_time;
        logic signed [SPAN_W-1:0] wait_time;
        logic                     counted;
    } totals_t;

    logic signed [LIMIT_W-1:0]    low_lim;
    logic signed [LIMIT_W-1:0]    high_lim;
    logic                         low_en;
    logic                         high_en;
    logic [GAP_W-1:0]             gap;
    logic                         cnt_mode;
    logic [TIME_BITS-1:0]         last_time;
    logic signed [VALUE_BITS-1:0] last_value;
    wide_t                        area_sum;
    wide_t                        worked_sum;
    wide_t                        off_sum;
    wide_t                        wait_sum;

    totals_t expected_totals[$];
    totals_t head;

    function automatic wide_t clamp(wide_t x, int w, bit is_signed);
        wide_t hi;
        wide_t lo;
        if (is_signed) begin
            hi = (wide_t'(1) <<< (w - 1)) - 1;
            lo = -(wide_t'(1) <<< (w - 1));
        end else begin
            hi = (wide_t'(1) <<< w) - 1;
            lo = '0;
        end
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // Closes the interval from the previous sample to this one and returns the new totals.
    function automatic totals_t advance_totals(logic [TIME_BITS-1:0] t,
                                               logic signed [VALUE_BITS-1:0] v);
        wide_t   span;
        wide_t   value;
        wide_t   prior;
        wide_t   inc;
        logic    below_gap;
        logic    in_range;
        logic    nonzero;
        logic    qualifies;
        totals_t r;
        span = $signed({{(128-TIME_BITS){1'b0}}, t})
             - $signed({{(128-TIME_BITS){1'b0}}, last_time});
        value = wide_t'(v);
        prior = wide_t'(last_value);
        below_gap = span < $signed({{(128-GAP_W){1'b0}}, gap});
        in_range = (!low_en || value >= low_lim) && (!high_en || value <= high_lim);
        nonzero = cnt_mode ? (value != 0 || prior != 0) : (value != 0);
        qualifies = span > 0 && below_gap && in_range && nonzero;
        r.counted = 1'b0;
        if (qualifies) begin
            if (!cnt_mode || prior != 0) begin
                // The arithmetic shift rounds the halved area toward minus infinity.
                inc = clamp(((value + prior) * span) >>> 1, AREA_W, 1'b1);
                area_sum = clamp(area_sum + inc, AREA_W, 1'b1);
                worked_sum = clamp(worked_sum + span, WORKED_W, 1'b0);
                r.counted = 1'b1;
            end
        end else begin
            off_sum = clamp(off_sum + span, SPAN_W, 1'b1);
            if (below_gap) begin
                wait_sum = clamp(wait_sum + span, SPAN_W, 1'b1);
            end
        end
        last_value = v;
        last_time = t;
        r.area = area_sum[AREA_W-1:0];
        r.worked = worked_sum[WORKED_W-1:0];
        r.off_time = off_sum[SPAN_W-1:0];
        r.wait_time = wait_sum[SPAN_W-1:0];
        return r;
    endfunction

    task automatic check_field(string label, wide_t want, wide_t got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            low_lim = LOW_LIMIT_RESET;
            high_lim = HIGH_LIMIT_RESET;
            low_en = 1'b0;
            high_en = 1'b0;
            gap = GAP_LIMIT_RESET;
            cnt_mode = 1'b0;
            last_time = START_TIME_RESET;
            last_value = '0;
            area_sum = '0;
            worked_sum = '0;
            off_sum = '0;
            wait_sum = '0;
            mismatches = 0;
            expected_totals.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LOW_LIMIT:    low_lim = cfg_data[LIMIT_W-1:0];
                    REG_HIGH_LIMIT:   high_lim = cfg_data[LIMIT_W-1:0];
                    REG_LOW_ENABLE:   low_en = cfg_data[0];
                    REG_HIGH_ENABLE:  high_en = cfg_data[0];
                    REG_GAP_LIMIT:    gap = cfg_data[GAP_W-1:0];
                    REG_START_TIME:   last_time = cfg_data[TIME_BITS-1:0];
                    REG_COUNTER_MODE: cnt_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_totals.push_back(advance_totals(s_sample_time, s_sample_value));
            end
            if (m_valid && m_ready) begin
                if (expected_totals.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word arrived with no sample outstanding", $time);
                end else begin
                    head = expected_totals.pop_front();
                    check_field("area_total", wide_t'(head.area), wide_t'(m_area_total));
                    check_field("worked_seconds", wide_t'(head.worked),
                                wide_t'(m_worked_seconds));
                    check_field("off_seconds", wide_t'(head.off_time), wide_t'(m_off_seconds));
                    check_field("wait_seconds", wide_t'(head.wait_time),
                                wide_t'(m_wait_seconds));
                    check_field("interval_counted", wide_t'(head.counted),
                                wide_t'(m_interval_counted));
                end
            end
        end
        totals_pending = expected_totals.size();
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import gatt_pkg::*;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam int TIMEOUT_CYCLES = 300000;

    typedef struct {
        logic signed [LIMIT_W-1:0] low_limit;
        logic signed [LIMIT_W-1:0] high_limit;
        logic                      low_enable;
        logic                      high_enable;
        logic [GAP_W-1:0]          gap_limit;
        logic [TIME_BITS-1:0]      start_time;
        logic                      counter_mode;
    } settings_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [CFG_INDEX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [TIME_BITS-1:0]         s_sample_time;
    logic signed [VALUE_BITS-1:0] s_sample_value;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [AREA_W-1:0]     m_area_total;
    logic [WORKED_W-1:0]          m_worked_seconds;
    logic signed [SPAN_W-1:0]     m_off_seconds;
    logic signed [SPAN_W-1:0]     m_wait_seconds;
    logic                         m_interval_counted;

    int mismatches;
    int totals_pending;

    settings_t            cur_cfg;
    logic [TIME_BITS-1:0] cur_time;
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   hold_req = 0;
    int                   hold_left = 0;

    gap_aware_trapezoid_totalizer i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_time      (s_sample_time),
        .s_sample_value     (s_sample_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_area_total       (m_area_total),
        .m_worked_seconds   (m_worked_seconds),
        .m_off_seconds      (m_off_seconds),
        .m_wait_seconds     (m_wait_seconds),
        .m_interval_counted (m_interval_counted)
    );

    totalizer_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_time      (s_sample_time),
        .s_sample_value     (s_sample_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_area_total       (m_area_total),
        .m_worked_seconds   (m_worked_seconds),
        .m_off_seconds      (m_off_seconds),
        .m_wait_seconds     (m_wait_seconds),
        .m_interval_counted (m_interval_counted),
        .mismatches         (mismatches),
        .totals_pending     (totals_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(20 * TIMEOUT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    // A hold request keeps the result channel stalled long enough for the pipeline to back up.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_sample(input logic [TIME_BITS-1:0] t,
                               input logic signed [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_time <= t;
        s_sample_value <= v;
        cur_time = t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (totals_pending != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
    endtask

    task automatic apply_settings(input settings_t s);
        write_reg(REG_LOW_LIMIT, s.low_limit);
        write_reg(REG_HIGH_LIMIT, s.high_limit);
        write_reg(REG_LOW_ENABLE, CFG_DATA_W'(s.low_enable));
        write_reg(REG_HIGH_ENABLE, CFG_DATA_W'(s.high_enable));
        write_reg(REG_GAP_LIMIT, s.gap_limit);
        write_reg(REG_START_TIME, s.start_time);
        write_reg(REG_COUNTER_MODE, CFG_DATA_W'(s.counter_mode));
        cfg_wr_en <= 1'b0;
        cur_cfg = s;
        cur_time = s.start_time;
    endtask

    function automatic logic signed [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(3))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return int'($urandom_range(262144, 0)) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic settings_t random_settings();
        settings_t s;
        s.low_limit = pick_limit();
        s.high_limit = pick_limit();
        s.low_enable = 1'($urandom_range(1));
        s.high_enable = 1'($urandom_range(1));
        case ($urandom_range(5))
            0: s.gap_limit = 1;
            1: s.gap_limit = 2880;
            2: s.gap_limit = 32'hFFFF_FFFF;
            default: s.gap_limit = $urandom_range(4000, 2);
        endcase
        case ($urandom_range(2))
            0: s.start_time = '0;
            1: s.start_time = 32'hFFFF_FFFF;
            default: s.start_time = $urandom;
        endcase
        s.counter_mode = 1'($urandom_range(1));
        return s;
    endfunction

    // Mostly short intervals below the gap, with repeats, reversals, gaps and wild jumps mixed in.
    function automatic logic [TIME_BITS-1:0] pick_time();
        int unsigned      r;
        logic [GAP_W-1:0] g;
        logic [GAP_W-1:0] reach;
        r = $urandom_range(99);
        g = cur_cfg.gap_limit;
        reach = (g > 5001) ? 5000 : ((g > 1) ? g - 1 : 1);
        if (r < 55) return cur_time + $urandom_range(reach, 1);
        if (r < 63) return cur_time;
        if (r < 72) return cur_time - $urandom_range(5000, 1);
        if (r < 82) return cur_time + g - 1 + $urandom_range(2, 0);
        if (r < 90) return $urandom;
        return cur_time + $urandom_range(200000, 1);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        logic signed [VALUE_BITS-1:0] v;
        if ($urandom_range(99) < (cur_cfg.counter_mode ? 30 : 14)) return '0;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return 1;
                    default: return -1;
                endcase
            end
            1, 2: begin
                case ($urandom_range(3))
                    0: return cur_cfg.low_limit;
                    1: return cur_cfg.high_limit;
                    2: return cur_cfg.low_limit - 1;
                    default: return cur_cfg.high_limit + 1;
                endcase
            end
            3, 4, 5: begin
                v = $urandom_range(32'h0010_0000, 1);
                if ($urandom_range(1)) v = -v;
                return v;
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        settings_t                    plan;
        logic signed [VALUE_BITS-1:0] v;
        int                           items;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_sample_time = '0;
        s_sample_value = '0;
        cur_cfg = '{VALUE_MIN, VALUE_MAX, 1'b0, 1'b0, 32'd2880, 32'd0, 1'b0};
        cur_time = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults: repeated and reversed time, an interval of exactly the gap,
        // a zero value, full-scale values, halving of an odd negative sum, and time wrap.
        send_sample(10, 32'sh0001_0000);
        send_sample(10, 32'sh0001_0000);
        send_sample(4, 5);
        send_sample(2884, 7);
        send_sample(5763, VALUE_MAX);
        send_sample(5764, VALUE_MAX);
        send_sample(5765, VALUE_MIN);
        send_sample(5766, 0);
        send_sample(32'hFFFF_FFFF, -1);
        send_sample(0, -1);
        send_sample(3, VALUE_MIN);
        settle();

        // Values on and just past both limits, then the counter channel rule.
        plan = '{-32'sd100, 32'sd100, 1'b1, 1'b1, 32'd50, 32'd1000, 1'b0};
        apply_settings(plan);
        send_sample(1001, -100);
        send_sample(1002, -101);
        send_sample(1003, 100);
        send_sample(1004, 101);
        send_sample(1054, 5);
        send_sample(1103, 5);
        settle();
        plan.start_time = 1103;
        plan.counter_mode = 1'b1;
        apply_settings(plan);
        send_sample(1104, 0);
        send_sample(1105, 0);
        send_sample(1106, 7);
        send_sample(1107, 7);
        send_sample(1107, 7);

        for (int phase = 0; phase < 13; phase++) begin
            settle();
            case (phase)
                0: plan = '{VALUE_MIN, VALUE_MAX, 1'b1, 1'b1, 32'd1, 32'd0, 1'b0};
                1: plan = '{VALUE_MAX, VALUE_MIN, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
                2: plan = '{VALUE_MIN, VALUE_MAX, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0};
                default: plan = random_settings();
            endcase
            apply_settings(plan);
            case (phase % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 70;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 70;
                end
                default: begin
                    idle_pct = 37;
                    stall_pct = 37;
                end
            endcase
            if (phase == 4) hold_req = 120;
            items = (phase == 2) ? 360 : 100;
            for (int k = 0; k < items; k++) begin
                if (phase == 2) begin
                    // Long qualifying climbs followed by drops back near zero drive every
                    // accumulator into saturation, the area first upward and then downward.
                    v = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
                    if (k >= items / 2) v = -v;
                    if (k % 2 == 0) begin
                        send_sample(cur_time + $urandom_range(32'hFFFF_F000, 32'hC000_0000), v);
                    end else begin
                        send_sample($urandom_range(1000, 0), v);
                    end
                end else begin
                    send_sample(pick_time(), pick_value());
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
